/* rtl/core/ttwr_pkg.sv */
// Shared constants, register indexes and transaction types of the window readout.
package ttwr_pkg;

   localparam int PRE_DEPTH     = 32;
   localparam int SAMPLE_BITS   = 14;
   localparam int PTR_BITS      = (PRE_DEPTH > 1) ? $clog2(PRE_DEPTH) : 1;
   localparam int CNT_BITS      = $clog2(PRE_DEPTH + 1);
   localparam int TICK_BITS     = 16;
   localparam int STOP_BITS     = TICK_BITS + 1;
   localparam int BASE_BITS     = 14;
   localparam int PRE_LEN_BITS  = 6;
   localparam int CH_BITS       = 10;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int AMP_BITS      = ((SAMPLE_BITS > BASE_BITS) ? SAMPLE_BITS : BASE_BITS) + 2;

   localparam logic [CSR_IDX_BITS-1:0] REG_BASELINE  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_NEG_POL   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_PRE_LEN   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_POST_LEN  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_REC_LEN   = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_CHANNEL   = 3'd6;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   forced_trigger;
   } ttwr_req_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] out_sample;
      logic [TICK_BITS-1:0]   segment_start_tick;
      logic [CH_BITS-1:0]     out_channel;
      logic                   first_of_segment;
      logic                   last_of_segment;
   } ttwr_rsp_type;

   typedef struct packed {
      logic [BASE_BITS-1:0]    baseline;
      logic [BASE_BITS-1:0]    threshold;
      logic                    negative_polarity;
      logic [PRE_LEN_BITS-1:0] pretrigger_len;
      logic [TICK_BITS-1:0]    posttrigger_len;
      logic [TICK_BITS-1:0]    record_length;
      logic [CH_BITS-1:0]      channel_id;
   } ttwr_cfg_type;

   // Window control state kept in flops.
   typedef struct packed {
      logic [TICK_BITS-1:0] tick;
      logic [PTR_BITS-1:0]  ptr;
      logic                 above;
      logic                 open;
      logic [TICK_BITS-1:0] start;
      logic [STOP_BITS-1:0] stop;
   } ttwr_ctl_type;

   // Per-item decision from the trigger unit.
   typedef struct packed {
      ttwr_ctl_type         nxt;
      logic                 emit;
      logic                 first;
      logic                 last;
      logic [TICK_BITS-1:0] seg_start;
      logic                 burst;
      logic [CNT_BITS-1:0]  cnt;
      logic [PTR_BITS-1:0]  rd_ptr;
   } ttwr_dec_type;

endpackage

/* rtl/core/threshold_trigger_window_readout.sv */
// Top level of the self-triggered digitizer window readout for one channel.
//
// One ADC sample enters per req transaction, with an optional forced (beam
// gate) trigger. A trigger fires when the polarity-corrected amplitude first
// reaches the threshold, or on the forced flag. A trigger with no window open
// opens one and sends the buffered pre-trigger samples, oldest first, then the
// current sample; a trigger inside an open window moves its stop tick later.
// Every sample inside an open window goes out as one rsp transaction tagged
// with the window's start tick and the channel number; the final sample of a
// window carries last_of_segment. The tick counter wraps after record_length
// samples and every record closes its window. Items that open no window with
// buffered history stream at one per clock while the rsp side takes results.
// An item that opens a window with n buffered pre-trigger samples (n up to
// PRE_DEPTH) holds req off until its burst is done: the history ring has one
// read port with a registered read, and each buffered sample is read and then
// emitted in two steps before the current sample goes out and is written back.
// A single output register holds each result; a stalled rsp side stalls req.
// Registers are written over the csr channel, which is always ready; the user
// must write them only while the block is idle, and the block does not enforce it.
module threshold_trigger_window_readout (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  ttwr_pkg::ttwr_req_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output ttwr_pkg::ttwr_rsp_type             rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ttwr_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [ttwr_pkg::CSR_DATA_BITS-1:0] csr_wr_data
);
   import ttwr_pkg::*;

   // Sequencer states.
   localparam logic [1:0] S_IDLE = 2'd0;  // accept the next sample
   localparam logic [1:0] S_READ = 2'd1;  // read one pre-trigger sample
   localparam logic [1:0] S_EMIT = 2'd2;  // send the sample just read
   localparam logic [1:0] S_CUR  = 2'd3;  // send the current sample, write it back

   logic [1:0]             state_ff, state_in;
   ttwr_cfg_type           cfg_ff, cfg_in;
   ttwr_ctl_type           ctl_ff, ctl_in;
   ttwr_dec_type           dec;
   logic                   rsp_valid_ff, rsp_valid_in;
   ttwr_rsp_type           rsp_data_ff, rsp_data_in;

   // Work registers of a burst in progress.
   logic [SAMPLE_BITS-1:0] cur_sample_ff, cur_sample_in;
   logic [PTR_BITS-1:0]    cur_addr_ff, cur_addr_in;
   logic                   cur_last_ff, cur_last_in;
   logic [TICK_BITS-1:0]   seg_start_ff, seg_start_in;
   logic [PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                   burst_first_ff, burst_first_in;

   logic                   out_free;
   logic                   accept;
   logic                   ring_wr_en;
   logic [PTR_BITS-1:0]    ring_wr_addr;
   logic [SAMPLE_BITS-1:0] ring_wr_data;
   logic                   ring_rd_en;
   logic [SAMPLE_BITS-1:0] ring_rd_data;

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign req_ready = (state_ff == S_IDLE) & out_free;
   assign accept    = req_valid & req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   ttwr_trig u_trig (
      .cfg (cfg_ff),
      .ctl (ctl_ff),
      .req (req_data),
      .dec (dec)
   );

   // The current sample goes into the ring only after any burst has read the
   // history, so a full-depth pre-trigger span still sees the oldest entry.
   assign ring_wr_en   = (accept & ~dec.burst) | ((state_ff == S_CUR) & out_free);
   assign ring_wr_addr = (state_ff == S_IDLE) ? ctl_ff.ptr : cur_addr_ff;
   assign ring_wr_data = (state_ff == S_IDLE) ? req_data.sample : cur_sample_ff;
   assign ring_rd_en   = (state_ff == S_READ);

   ttwr_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ring_wr_en),
      .wr_addr (ring_wr_addr),
      .wr_data (ring_wr_data),
      .rd_en   (ring_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ring_rd_data)
   );

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_BASELINE:  cfg_in.baseline          = csr_wr_data[BASE_BITS-1:0];
            REG_THRESHOLD: cfg_in.threshold         = csr_wr_data[BASE_BITS-1:0];
            REG_NEG_POL:   cfg_in.negative_polarity = csr_wr_data[0];
            REG_PRE_LEN:   cfg_in.pretrigger_len    = csr_wr_data[PRE_LEN_BITS-1:0];
            REG_POST_LEN:  cfg_in.posttrigger_len   = csr_wr_data[TICK_BITS-1:0];
            REG_REC_LEN:   cfg_in.record_length     = csr_wr_data[TICK_BITS-1:0];
            REG_CHANNEL:   cfg_in.channel_id        = csr_wr_data[CH_BITS-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   // Sequencer, window state and output register.
   always_comb begin
      state_in       = state_ff;
      ctl_in         = ctl_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_data_in    = rsp_data_ff;
      cur_sample_in  = cur_sample_ff;
      cur_addr_in    = cur_addr_ff;
      cur_last_in    = cur_last_ff;
      seg_start_in   = seg_start_ff;
      rd_ptr_in      = rd_ptr_ff;
      cnt_in         = cnt_ff;
      burst_first_in = burst_first_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // Window state commits at once; the burst runs on copies.
               ctl_in = dec.nxt;
               if (dec.burst) begin
                  cur_sample_in  = req_data.sample;
                  cur_addr_in    = ctl_ff.ptr;
                  cur_last_in    = dec.last;
                  seg_start_in   = dec.seg_start;
                  rd_ptr_in      = dec.rd_ptr;
                  cnt_in         = dec.cnt;
                  burst_first_in = 1'b1;
                  state_in       = S_READ;
               end else if (dec.emit) begin
                  rsp_valid_in                   = 1'b1;
                  rsp_data_in.out_sample         = req_data.sample;
                  rsp_data_in.segment_start_tick = dec.seg_start;
                  rsp_data_in.out_channel        = cfg_ff.channel_id;
                  rsp_data_in.first_of_segment   = dec.first;
                  rsp_data_in.last_of_segment    = dec.last;
               end
            end
         end
         S_READ: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in                   = 1'b1;
               rsp_data_in.out_sample         = ring_rd_data;
               rsp_data_in.segment_start_tick = seg_start_ff;
               rsp_data_in.out_channel        = cfg_ff.channel_id;
               rsp_data_in.first_of_segment   = burst_first_ff;
               rsp_data_in.last_of_segment    = 1'b0;
               burst_first_in = 1'b0;
               rd_ptr_in      = (rd_ptr_ff == PTR_BITS'(PRE_DEPTH - 1))
                                ? '0 : rd_ptr_ff + PTR_BITS'(1);
               cnt_in         = cnt_ff - CNT_BITS'(1);
               state_in       = (cnt_ff == CNT_BITS'(1)) ? S_CUR : S_READ;
            end
         end
         S_CUR: begin
            if (out_free) begin
               rsp_valid_in                   = 1'b1;
               rsp_data_in.out_sample         = cur_sample_ff;
               rsp_data_in.segment_start_tick = seg_start_ff;
               rsp_data_in.out_channel        = cfg_ff.channel_id;
               rsp_data_in.first_of_segment   = 1'b0;
               rsp_data_in.last_of_segment    = cur_last_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff                 <= S_IDLE;
         rsp_valid_ff             <= 1'b0;
         cfg_ff.baseline          <= BASE_BITS'(8000);
         cfg_ff.threshold         <= BASE_BITS'(13);
         cfg_ff.negative_polarity <= 1'b1;
         cfg_ff.pretrigger_len    <= PRE_LEN_BITS'(8);
         cfg_ff.posttrigger_len   <= TICK_BITS'(24);
         cfg_ff.record_length     <= TICK_BITS'(4096);
         cfg_ff.channel_id        <= '0;
         ctl_ff.tick              <= '0;
         ctl_ff.ptr               <= '0;
         ctl_ff.above             <= 1'b0;
         ctl_ff.open              <= 1'b0;
         ctl_ff.start             <= '0;
         ctl_ff.stop              <= STOP_BITS'(4096);
         cnt_ff                   <= '0;
         burst_first_ff           <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         cfg_ff         <= cfg_in;
         ctl_ff         <= ctl_in;
         cnt_ff         <= cnt_in;
         burst_first_ff <= burst_first_in;
      end
   end

   // Payload registers hold without reset.
   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      cur_sample_ff <= cur_sample_in;
      cur_addr_ff   <= cur_addr_in;
      cur_last_ff   <= cur_last_in;
      seg_start_ff  <= seg_start_in;
      rd_ptr_ff     <= rd_ptr_in;
   end

endmodule

/* rtl/core/ttwr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module ttwr_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 32
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/ttwr_ring.sv */
// Pre-trigger history ring: RAM plus per-entry written flags so unwritten entries read as zero.
module ttwr_ring (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [ttwr_pkg::PTR_BITS-1:0]    wr_addr,
   input  logic [ttwr_pkg::SAMPLE_BITS-1:0] wr_data,
   input  logic                            rd_en,
   input  logic [ttwr_pkg::PTR_BITS-1:0]    rd_addr,
   output logic [ttwr_pkg::SAMPLE_BITS-1:0] rd_data
);
   import ttwr_pkg::*;

   logic [PRE_DEPTH-1:0]   vld_ff;
   logic [PRE_DEPTH-1:0]   vld_in;
   logic                   rd_vld_ff;
   logic                   rd_vld_in;
   logic [SAMPLE_BITS-1:0] ram_q;

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
      rd_vld_in = rd_en ? vld_ff[rd_addr] : rd_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   ttwr_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (PRE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign rd_data = rd_vld_ff ? ram_q : '0;

endmodule

/* rtl/core/ttwr_trig.sv */
// Trigger detection and window bound update for one accepted sample.
module ttwr_trig (
   input  ttwr_pkg::ttwr_cfg_type cfg,
   input  ttwr_pkg::ttwr_ctl_type ctl,
   input  ttwr_pkg::ttwr_req_type req,
   output ttwr_pkg::ttwr_dec_type dec
);
   import ttwr_pkg::*;

   logic [TICK_BITS-1:0]   len;
   logic [TICK_BITS-1:0]   post;
   logic [CNT_BITS-1:0]    pre;
   logic [STOP_BITS-1:0]   i_plus1;
   logic                   rec_end;
   logic signed [AMP_BITS-1:0] amp;
   logic                   ge;
   logic                   trig;
   logic [TICK_BITS-1:0]   rem;
   logic [STOP_BITS-1:0]   stop_new;
   logic                   opening;
   logic                   i_gt_pre;
   logic [TICK_BITS-1:0]   start_new;
   logic [CNT_BITS-1:0]    cnt;
   logic [STOP_BITS-1:0]   stop_eff;
   logic                   open_eff;
   logic                   closing;
   logic [CNT_BITS:0]      ptr_ext;
   logic [CNT_BITS:0]      cnt_ext;

   always_comb begin
      len  = (cfg.record_length == '0) ? TICK_BITS'(1) : cfg.record_length;
      post = (cfg.posttrigger_len == '0) ? TICK_BITS'(1) : cfg.posttrigger_len;
      pre  = ({1'b0, cfg.pretrigger_len} > (PRE_LEN_BITS + 1)'(PRE_DEPTH))
             ? CNT_BITS'(PRE_DEPTH) : CNT_BITS'(cfg.pretrigger_len);

      i_plus1 = {1'b0, ctl.tick} + STOP_BITS'(1);
      rec_end = i_plus1 >= {1'b0, len};

      // Polarity-corrected amplitude against the threshold.
      if (cfg.negative_polarity) begin
         amp = $signed(AMP_BITS'(cfg.baseline)) - $signed(AMP_BITS'(req.sample));
      end else begin
         amp = $signed(AMP_BITS'(req.sample)) - $signed(AMP_BITS'(cfg.baseline));
      end
      ge   = amp >= $signed(AMP_BITS'(cfg.threshold));
      trig = req.forced_trigger | (~ctl.above & ge);

      // Stop tick, clamped to the record end.
      rem = len - TICK_BITS'(1) - ctl.tick;
      if (!rec_end && (rem > post)) begin
         stop_new = {1'b0, ctl.tick} + {1'b0, post};
      end else begin
         stop_new = {1'b0, len};
      end

      opening  = trig & ~ctl.open;
      i_gt_pre = ctl.tick > TICK_BITS'(pre);
      if (opening) begin
         start_new = i_gt_pre ? (ctl.tick - TICK_BITS'(pre)) : '0;
         cnt       = i_gt_pre ? pre : CNT_BITS'(ctl.tick);
      end else begin
         start_new = ctl.start;
         cnt       = '0;
      end
      stop_eff = trig ? stop_new : ctl.stop;
      open_eff = ctl.open | trig;
      closing  = (i_plus1 == stop_eff) | rec_end;

      // Ring slot of the oldest pre-trigger sample.
      ptr_ext = (CNT_BITS + 1)'(ctl.ptr);
      cnt_ext = (CNT_BITS + 1)'(cnt);
      if (ptr_ext >= cnt_ext) begin
         dec.rd_ptr = PTR_BITS'(ptr_ext - cnt_ext);
      end else begin
         dec.rd_ptr = PTR_BITS'(ptr_ext + (CNT_BITS + 1)'(PRE_DEPTH) - cnt_ext);
      end

      dec.emit      = open_eff;
      dec.first     = opening & (cnt == '0);
      dec.last      = closing;
      dec.seg_start = start_new;
      dec.burst     = opening & (cnt != '0);
      dec.cnt       = cnt;

      if (rec_end) begin
         dec.nxt.tick  = '0;
         dec.nxt.ptr   = '0;
         dec.nxt.above = 1'b0;
         dec.nxt.open  = 1'b0;
         dec.nxt.start = '0;
         dec.nxt.stop  = {1'b0, len};
      end else begin
         dec.nxt.tick  = ctl.tick + TICK_BITS'(1);
         dec.nxt.ptr   = (ctl.ptr == PTR_BITS'(PRE_DEPTH - 1)) ? '0 : ctl.ptr + PTR_BITS'(1);
         dec.nxt.above = ge;
         dec.nxt.open  = open_eff & ~closing;
         dec.nxt.start = start_new;
         dec.nxt.stop  = stop_eff;
      end
   end

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the threshold-triggered window readout.
`timescale 1ns / 1ps

module testbench;
   import ttwr_pkg::*;

   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 4;
   // Longest item is a full pre-trigger burst; leave margin beyond it.
   localparam int SETTLE_CYCLES   = 2 * PRE_DEPTH + 16;
   localparam int SQUEEZE_CYCLES  = 300;
   localparam int ITEMS_PER_PHASE = 36;
   localparam int NUM_PHASES      = 6;
   localparam int SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;
   localparam int BY_MODEL        = -1;
   localparam int RUN_LIMIT_NS    = 10_000_000;

   typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_type;
   typedef enum logic [1:0] {FLOW, COIN, EVERY_FOURTH, MOSTLY} stall_mode_type;

   // One step of the directed plan: a sample transaction or a register write.
   // typed_count is BY_MODEL when the predictor supplies the expected results,
   // else the number (0 or 1) of results typed in by hand.
   typedef struct {
      row_kind_type             kind;
      logic [CSR_IDX_BITS-1:0]  reg_index;
      logic [CSR_DATA_BITS-1:0] reg_value;
      ttwr_req_type             item;
      int                       typed_count;
      ttwr_rsp_type             typed_rsp;
   } plan_row_type;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_ready;
   ttwr_req_type             req_data    = '0;
   logic                     rsp_valid;
   logic                     rsp_ready   = 1'b0;
   ttwr_rsp_type             rsp_data;
   logic                     csr_valid   = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index   = '0;
   logic [CSR_DATA_BITS-1:0] csr_wr_data = '0;

   // Set once by the stimulus side; the result side then runs one long hold-off.
   logic squeeze_armed = 1'b0;

   // Window predictor: configuration and state as they stand after reset.
   ttwr_cfg_type cfg_model = '{baseline: 14'd8000, threshold: 14'd13,
                               negative_polarity: 1'b1, pretrigger_len: 6'd8,
                               posttrigger_len: 16'd24, record_length: 16'd4096,
                               channel_id: 10'd0};
   logic [SAMPLE_BITS-1:0] sample_hist [PRE_DEPTH] = '{default: '0};
   int unsigned            tick_now  = 0;
   bit                     above_now = 1'b0;
   bit                     win_open  = 1'b0;
   int unsigned            win_start = 0;
   int unsigned            win_stop  = 4096;

   ttwr_rsp_type samples_due[$];   // window samples still to come, oldest first
   plan_row_type plan[$];
   int           mismatch_count = 0;
   int unsigned  burst_left     = 0;

   always #HALF_PERIOD clock = ~clock;

   threshold_trigger_window_readout uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   function automatic ttwr_rsp_type make_rsp(input logic [SAMPLE_BITS-1:0] s,
                                             input int unsigned start,
                                             input logic [CH_BITS-1:0] ch,
                                             input bit first, input bit last);
      ttwr_rsp_type r;
      r.out_sample         = s;
      r.segment_start_tick = TICK_BITS'(start);
      r.out_channel        = ch;
      r.first_of_segment   = first;
      r.last_of_segment    = last;
      return r;
   endfunction

   // Advance the predictor by one sample and collect the window samples it emits.
   function automatic void predict_window(input ttwr_req_type item, ref ttwr_rsp_type outs[$]);
      int unsigned idx, len, pre, post, stop_new, t;
      int          amp;
      bit          trig, rec_end, opened, closing;
      idx      = tick_now;
      len      = (cfg_model.record_length == 0) ? 1 : cfg_model.record_length;
      pre      = (cfg_model.pretrigger_len > PRE_DEPTH) ? PRE_DEPTH : cfg_model.pretrigger_len;
      post     = (cfg_model.posttrigger_len == 0) ? 1 : cfg_model.posttrigger_len;
      trig     = item.forced_trigger;
      rec_end  = (idx + 1 >= len);
      opened   = 1'b0;
      outs     = {};
      if (cfg_model.negative_polarity)
         amp = int'(cfg_model.baseline) - int'(item.sample);
      else
         amp = int'(item.sample) - int'(cfg_model.baseline);

      // Fire on the rising crossing only; drop the flag once back below.
      if (!above_now && amp >= int'(cfg_model.threshold)) begin
         above_now = 1'b1;
         trig      = 1'b1;
      end else if (above_now && amp < int'(cfg_model.threshold)) begin
         above_now = 1'b0;
      end

      // Clamp the stop tick to the record end when the post-trigger span would pass it.
      stop_new = (!rec_end && (len - 1 - idx) > post) ? idx + post : len;

      if (trig) begin
         if (!win_open) begin
            win_open  = 1'b1;
            opened    = 1'b1;
            win_start = (idx > pre) ? idx - pre : 0;
            win_stop  = stop_new;
            // Replay the buffered history, even samples already sent by an earlier window.
            for (t = win_start; t < idx; t++)
               outs.push_back(make_rsp(sample_hist[t % PRE_DEPTH], win_start,
                                       cfg_model.channel_id, t == win_start, 1'b0));
         end else begin
            win_stop = stop_new;
         end
      end

      if (win_open) begin
         closing = (idx + 1 == win_stop) || rec_end;
         outs.push_back(make_rsp(item.sample, win_start, cfg_model.channel_id,
                                 opened && win_start == idx, closing));
         if (closing)
            win_open = 1'b0;
      end

      sample_hist[idx % PRE_DEPTH] = item.sample;

      if (rec_end) begin
         tick_now  = 0;
         above_now = 1'b0;
         win_open  = 1'b0;
         win_start = 0;
         win_stop  = len;
      end else begin
         tick_now = idx + 1;
      end
   endfunction

   function automatic void add_sample(input int s, input bit forced, input int typed_count,
                                      input ttwr_rsp_type typed_rsp);
      plan_row_type row;
      row.kind                = ROW_ITEM;
      row.reg_index           = '0;
      row.reg_value           = '0;
      row.item.sample         = SAMPLE_BITS'(s);
      row.item.forced_trigger = forced;
      row.typed_count         = typed_count;
      row.typed_rsp           = typed_rsp;
      plan.push_back(row);
   endfunction

   function automatic void add_write(input logic [CSR_IDX_BITS-1:0] index,
                                     input int unsigned value);
      plan_row_type row;
      row.kind        = ROW_WRITE;
      row.reg_index   = index;
      row.reg_value   = CSR_DATA_BITS'(value);
      row.item        = '0;
      row.typed_count = 0;
      row.typed_rsp   = '0;
      plan.push_back(row);
   endfunction

   task automatic report_mismatch(input string what, input int result_no,
                                  input int got, input int want);
      $display("mismatch in result %0d, %s: got %0d, want %0d", result_no, what, got, want);
      mismatch_count++;
   endtask

   // Write one register. Leave csr_valid high so back-to-back writes need no
   // second assignment in one step; the caller drops it after the last write.
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_valid   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (index)
         REG_BASELINE:  cfg_model.baseline          = value[BASE_BITS-1:0];
         REG_THRESHOLD: cfg_model.threshold         = value[BASE_BITS-1:0];
         REG_NEG_POL:   cfg_model.negative_polarity = value[0];
         REG_PRE_LEN:   cfg_model.pretrigger_len    = value[PRE_LEN_BITS-1:0];
         REG_POST_LEN:  cfg_model.posttrigger_len   = value[TICK_BITS-1:0];
         REG_REC_LEN:   cfg_model.record_length     = value[TICK_BITS-1:0];
         REG_CHANNEL:   cfg_model.channel_id        = value[CH_BITS-1:0];
         default: ;
      endcase
   endtask

   // Drain every expected result, then give the block time to finish an item
   // that emits nothing (its history write-back) before registers change.
   task automatic settle();
      req_valid <= 1'b0;
      while (samples_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Predict, then offer one sample transaction. Predict before the handshake:
   // the payload is fixed once offered, and the block may start on it early.
   task automatic send_sample(input ttwr_req_type item, input int typed_count,
                              input ttwr_rsp_type typed_rsp);
      ttwr_rsp_type predicted[$];
      int unsigned  gap;
      predict_window(item, predicted);
      if (typed_count == BY_MODEL)
         foreach (predicted[k]) samples_due.push_back(predicted[k]);
      else if (typed_count == 1)
         samples_due.push_back(typed_rsp);

      // Bursts of random length with random gaps; some bursts run long with no idling.
      if (burst_left == 0) begin
         gap = $urandom_range(0, 7);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   initial begin : stimulus
      ttwr_cfg_type phase_cfg [NUM_PHASES];
      ttwr_req_type item;
      int           amp, hi, pick, pulse_left, s, thr, base;
      bit           wrote_last;

      // Reset values: baseline 8000, threshold 13, negative pulses, 8 pre, 24 post.
      add_sample(8000, 1'b0, 0, '0);            // at baseline: nothing
      add_sample(SAMPLE_MAX, 1'b0, 0, '0);      // full scale, wrong polarity: nothing
      add_sample(0, 1'b0, BY_MODEL, '0);        // deep pulse opens, replays two samples
      add_sample(7990, 1'b0, BY_MODEL, '0);     // back under threshold, still in window
      add_sample(7987, 1'b0, BY_MODEL, '0);     // exactly at threshold: extend stop
      add_sample(8000, 1'b1, BY_MODEL, '0);     // forced trigger inside open window
      // Touch every register while the window stays open; its bounds must hold.
      add_write(REG_BASELINE, 0);
      add_write(REG_THRESHOLD, SAMPLE_MAX);
      add_write(REG_NEG_POL, 0);
      add_write(REG_PRE_LEN, 4);
      add_write(REG_POST_LEN, 2);
      add_write(REG_REC_LEN, 8);
      add_write(REG_CHANNEL, 1023);
      add_sample(100, 1'b0, BY_MODEL, '0);
      add_sample(200, 1'b0, BY_MODEL, '0);      // lowered record ends: close window
      add_sample(SAMPLE_MAX, 1'b0, 1, make_rsp(14'(SAMPLE_MAX), 0, 10'd1023, 1'b1, 1'b0));
      add_sample(5, 1'b0, 1, make_rsp(14'd5, 0, 10'd1023, 1'b0, 1'b1));
      add_sample(SAMPLE_MAX, 1'b0, BY_MODEL, '0); // reopen: resend the previous window
      add_sample(1, 1'b0, BY_MODEL, '0);
      add_sample(2, 1'b0, 0, '0);
      add_sample(3, 1'b1, BY_MODEL, '0);        // forced, stop clamped to record end
      add_sample(4, 1'b0, BY_MODEL, '0);
      add_sample(6, 1'b0, BY_MODEL, '0);
      // Out-of-range pre length, zero post length and zero record length.
      add_write(REG_PRE_LEN, 63);
      add_write(REG_POST_LEN, 0);
      add_write(REG_REC_LEN, 0);
      add_sample(SAMPLE_MAX, 1'b0, 1, make_rsp(14'(SAMPLE_MAX), 0, 10'd1023, 1'b1, 1'b1));
      add_sample(7, 1'b1, 1, make_rsp(14'd7, 0, 10'd1023, 1'b1, 1'b1));
      add_sample(7, 1'b0, 0, '0);
      add_write(REG_REC_LEN, 64);
      add_sample(9, 1'b1, 1, make_rsp(14'd9, 0, 10'd1023, 1'b1, 1'b1));
      add_sample(SAMPLE_MAX, 1'b0, BY_MODEL, '0);

      phase_cfg[0] = '{baseline: 14'd8000, threshold: 14'd13, negative_polarity: 1'b1,
                       pretrigger_len: 6'd8, posttrigger_len: 16'd24,
                       record_length: 16'd4096, channel_id: 10'd5};
      phase_cfg[1] = '{baseline: 14'd2000, threshold: 14'd300, negative_polarity: 1'b0,
                       pretrigger_len: 6'd32, posttrigger_len: 16'd5,
                       record_length: 16'd100, channel_id: 10'd1023};
      phase_cfg[2] = '{baseline: 14'd16383, threshold: 14'd0, negative_polarity: 1'b1,
                       pretrigger_len: 6'd0, posttrigger_len: 16'd1,
                       record_length: 16'd37, channel_id: 10'd0};
      phase_cfg[3] = '{baseline: 14'd0, threshold: 14'd16383, negative_polarity: 1'b0,
                       pretrigger_len: 6'd63, posttrigger_len: 16'd65535,
                       record_length: 16'd65535, channel_id: 10'd512};
      phase_cfg[4] = '{baseline: 14'd9000, threshold: 14'd50, negative_polarity: 1'b1,
                       pretrigger_len: 6'd20, posttrigger_len: 16'd3,
                       record_length: 16'd1, channel_id: 10'd77};
      phase_cfg[5] = '{baseline: 14'd5000, threshold: 14'd40, negative_polarity: 1'b0,
                       pretrigger_len: 6'd12, posttrigger_len: 16'd10,
                       record_length: 16'd60, channel_id: 10'd300};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed plan; drain before a run of register writes and drop
      // csr_valid once the run is over.
      wrote_last = 1'b0;
      foreach (plan[r]) begin
         if (plan[r].kind == ROW_WRITE) begin
            if (!wrote_last)
               settle();
            write_reg(plan[r].reg_index, plan[r].reg_value);
            wrote_last = 1'b1;
         end else begin
            if (wrote_last)
               csr_valid <= 1'b0;
            wrote_last = 1'b0;
            send_sample(plan[r].item, plan[r].typed_count, plan[r].typed_rsp);
         end
      end

      // Random phases: mostly quiet samples near baseline, pulses a few ticks long
      // that cross the threshold, some raw full-range noise and rare forced triggers.
      foreach (phase_cfg[p]) begin
         settle();
         write_reg(REG_BASELINE,  CSR_DATA_BITS'(phase_cfg[p].baseline));
         write_reg(REG_THRESHOLD, CSR_DATA_BITS'(phase_cfg[p].threshold));
         write_reg(REG_NEG_POL,   CSR_DATA_BITS'(phase_cfg[p].negative_polarity));
         write_reg(REG_PRE_LEN,   CSR_DATA_BITS'(phase_cfg[p].pretrigger_len));
         write_reg(REG_POST_LEN,  CSR_DATA_BITS'(phase_cfg[p].posttrigger_len));
         write_reg(REG_REC_LEN,   CSR_DATA_BITS'(phase_cfg[p].record_length));
         write_reg(REG_CHANNEL,   CSR_DATA_BITS'(phase_cfg[p].channel_id));
         csr_valid <= 1'b0;
         // Long pre-trigger bursts here: the right phase to starve the result side.
         if (p == 1)
            squeeze_armed <= 1'b1;
         thr        = int'(phase_cfg[p].threshold);
         base       = int'(phase_cfg[p].baseline);
         pulse_left = 0;
         repeat (ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pulse_left == 0 && pick < 10) begin
               s = $urandom_range(0, SAMPLE_MAX);
            end else begin
               if (pulse_left != 0) begin
                  pulse_left--;
                  amp = thr + int'($urandom_range(0, 300));
               end else if (pick < 28) begin
                  pulse_left = $urandom_range(0, 3);
                  amp        = thr + int'($urandom_range(0, 300));
               end else begin
                  hi  = (thr > 60) ? 60 : thr - 1;
                  amp = -20 + int'($urandom_range(0, hi + 20));
               end
               s = phase_cfg[p].negative_polarity ? base - amp : base + amp;
               if (s < 0)
                  s = 0;
               else if (s > SAMPLE_MAX)
                  s = SAMPLE_MAX;
            end
            item.sample         = SAMPLE_BITS'(s);
            item.forced_trigger = ($urandom_range(0, 24) == 0);
            send_sample(item, BY_MODEL, '0);
         end
      end

      settle();
      if (mismatch_count == 0 && samples_due.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Result side: check each accepted transaction against the oldest expectation
   // and drive rsp_ready on a stall pattern of its own, with one long hold-off.
   initial begin : result_side
      stall_mode_type mode;
      int unsigned    mode_left, hold_left, cycle, result_no;
      bit             hold_done;
      ttwr_rsp_type   want;
      mode      = FLOW;
      mode_left = 0;
      hold_left = 0;
      cycle     = 0;
      result_no = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         cycle++;
         if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            if (samples_due.size() == 0) begin
               report_mismatch("nothing due, out_sample", int'(result_no),
                               int'(rsp_data.out_sample), -1);
            end else begin
               want = samples_due.pop_front();
               if (rsp_data.out_sample !== want.out_sample)
                  report_mismatch("out_sample", int'(result_no),
                                  int'(rsp_data.out_sample), int'(want.out_sample));
               if (rsp_data.segment_start_tick !== want.segment_start_tick)
                  report_mismatch("segment_start_tick", int'(result_no),
                                  int'(rsp_data.segment_start_tick),
                                  int'(want.segment_start_tick));
               if (rsp_data.out_channel !== want.out_channel)
                  report_mismatch("out_channel", int'(result_no),
                                  int'(rsp_data.out_channel), int'(want.out_channel));
               if (rsp_data.first_of_segment !== want.first_of_segment)
                  report_mismatch("first_of_segment", int'(result_no),
                                  int'(rsp_data.first_of_segment),
                                  int'(want.first_of_segment));
               if (rsp_data.last_of_segment !== want.last_of_segment)
                  report_mismatch("last_of_segment", int'(result_no),
                                  int'(rsp_data.last_of_segment),
                                  int'(want.last_of_segment));
            end
            result_no++;
         end

         if (mode_left == 0) begin
            mode      = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 96);
         end
         mode_left--;

         // Start the hold-off on the first result after arming; the sender keeps
         // offering, so the block fills up and must stall its input.
         if (squeeze_armed && !hold_done && rsp_valid === 1'b1) begin
            hold_left = SQUEEZE_CYCLES;
            hold_done = 1'b1;
         end

         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               FLOW:         rsp_ready <= 1'b1;
               COIN:         rsp_ready <= ($urandom_range(0, 1) == 1);
               EVERY_FOURTH: rsp_ready <= (cycle % 4 == 0);
               default:      rsp_ready <= ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      #RUN_LIMIT_NS;
      $display("tb: failure");
      $finish;
   end

endmodule
